### hdl/targa_rle_packet_encoder_macros.svh
// Assertion shorthands for the RLE packet encoder.
// Both expect aclk and aresetn in scope.
`ifndef TARGA_RLE_PACKET_ENCODER_MACROS_SVH
`define TARGA_RLE_PACKET_ENCODER_MACROS_SVH

// Same-cycle implication.
`define TRLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/trle_pkg.sv
`timescale 1ns / 1ps

package trle_pkg;

    localparam int RUN_THRESH = 2;
    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam int HDR_CNT_W = 7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_block;
    } trle_in_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last_of_item;
        logic        block_done;
    } trle_out_t;

    // Packet state updates.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_OPEN,
        OP_EQ,
        OP_DIFF,
        OP_CLOSE,
        OP_CLEAR
    } trle_op_t;

    typedef struct packed {
        logic     load;
        logic     from_in;
        logic     hdr;
        logic     adv;
        logic     seg_close;
        trle_op_t op;
    } trle_cmd_t;

    typedef struct packed {
        logic full;
        logic open;
        logic eq;
        logic is_run;
        logic rep_one;
        logic fill_gt3;
        logic last;
        logic body_last;
    } trle_stat_t;

    typedef struct packed {
        logic valid;
        logic item_end;
        logic block_end;
    } trle_emit_t;

endpackage

### hdl/trle_ctrl.sv
`timescale 1ns / 1ps

module trle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  trle_pkg::trle_stat_t stat,
    input  logic               byte_ready,
    output trle_pkg::trle_cmd_t  cmd,
    output trle_pkg::trle_emit_t emit
);
    import trle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_BODY
    } state_t;

    typedef enum logic [1:0] {
        PH_FULL,
        PH_CLOSE,
        PH_BREAK,
        PH_LAST
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   close_lit;
    logic   run_break;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        s_ready        = 1'b0;
        cmd.load       = 1'b0;
        cmd.from_in    = 1'b0;
        cmd.hdr        = 1'b0;
        cmd.adv        = 1'b0;
        cmd.seg_close  = (phase_reg == PH_CLOSE);
        cmd.op         = OP_NONE;
        emit.valid     = 1'b0;
        emit.item_end  = 1'b0;
        emit.block_end = 1'b0;

        // third equal byte behind a literal, or a differing byte behind a run
        close_lit = !stat.full && !stat.open && stat.eq && stat.rep_one && stat.fill_gt3;
        run_break = !stat.full && !stat.open && !stat.eq && stat.is_run;

        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.from_in = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.full) begin
                        phase_next = PH_FULL;
                        state_next = S_HDR;
                    end else if (close_lit) begin
                        phase_next = PH_CLOSE;
                        state_next = S_HDR;
                    end else if (run_break) begin
                        phase_next = PH_BREAK;
                        state_next = S_HDR;
                    end else begin
                        if (stat.open) begin
                            cmd.op = OP_OPEN;
                        end else if (stat.eq) begin
                            cmd.op = OP_EQ;
                        end else begin
                            cmd.op = OP_DIFF;
                        end
                        if (stat.last) begin
                            phase_next = PH_LAST;
                            state_next = S_HDR;
                        end
                    end
                end
            end
            S_HDR: begin
                emit.valid = 1'b1;
                cmd.hdr    = 1'b1;
                cmd.adv    = byte_ready;
                if (byte_ready) begin
                    state_next = S_BODY;
                end
            end
            S_BODY: begin
                emit.valid     = 1'b1;
                emit.item_end  = stat.body_last && (phase_reg == PH_LAST || !stat.last);
                emit.block_end = emit.item_end && stat.last;
                cmd.adv        = byte_ready;
                if (byte_ready && stat.body_last) begin
                    unique case (phase_reg) inside
                        PH_LAST: begin
                            cmd.op     = OP_CLEAR;
                            state_next = S_IDLE;
                        end
                        PH_FULL, PH_BREAK, PH_CLOSE: begin
                            cmd.op = (phase_reg == PH_CLOSE) ? OP_CLOSE : OP_OPEN;
                            if (stat.last) begin
                                phase_next = PH_LAST;
                                state_next = S_HDR;
                            end else begin
                                state_next = S_IDLE;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_LAST;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### hdl/trle_dpath.sv
`timescale 1ns / 1ps

module trle_dpath #(
    parameter int MAX_PACKET = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  trle_pkg::trle_in_t   s_item,
    input  trle_pkg::trle_cmd_t  cmd,
    output trle_pkg::trle_stat_t stat,
    output logic [7:0]           byte_data
);
    import trle_pkg::*;

    localparam int AW = $clog2(MAX_PACKET);
    localparam int FW = $clog2(MAX_PACKET + 2);
    localparam int RW = $clog2(MAX_PACKET);

    logic [7:0]    store_mem [MAX_PACKET];
    logic [7:0]    rd_data_reg;
    logic [FW-1:0] idx_reg;
    logic [7:0]    cur_byte_reg;
    logic          cur_last_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [RW-1:0] repeat_reg, repeat_next;
    logic [7:0]    match_reg, match_next;

    logic [7:0]    work_byte;
    logic [FW-1:0] fill_m1;
    logic [FW-1:0] seg_len;
    logic [FW-1:0] seg_len_m1;
    logic          run_kind;
    logic [7:0]    hdr_byte;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        work_byte = cmd.from_in ? s_item.in_byte : cur_byte_reg;
        fill_m1   = fill_reg - FW'(1);

        stat.full     = (fill_reg == FW'(MAX_PACKET + 1));
        stat.open     = (fill_reg <= FW'(1));
        stat.eq       = (work_byte == match_reg);
        stat.is_run   = (repeat_reg >= RW'(RUN_THRESH));
        stat.rep_one  = (repeat_reg == RW'(1));
        stat.fill_gt3 = (fill_reg > FW'(RUN_THRESH + 1));
        stat.last     = cmd.from_in ? s_item.last_in_block : cur_last_reg;

        // closing a literal leaves the two bytes that start the run behind
        seg_len    = cmd.seg_close ? fill_reg - FW'(RUN_THRESH + 1) : fill_m1;
        seg_len_m1 = seg_len - FW'(1);
        run_kind   = !cmd.seg_close && stat.is_run;
        stat.body_last = run_kind || (idx_reg == seg_len);

        hdr_byte  = (run_kind ? RUN_FLAG : 8'h00) | {1'b0, HDR_CNT_W'(seg_len_m1)};
        byte_data = cmd.hdr ? hdr_byte : (run_kind ? match_reg : rd_data_reg);

        fill_next   = fill_reg;
        repeat_next = repeat_reg;
        match_next  = match_reg;
        wr_en       = 1'b0;
        wr_addr     = fill_m1[AW-1:0];
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_OPEN: begin
                repeat_next = '0;
                match_next  = work_byte;
                fill_next   = FW'(2);
                wr_en       = 1'b1;
                wr_addr     = '0;
            end
            OP_EQ: begin
                repeat_next = repeat_reg + RW'(1);
                fill_next   = fill_reg + FW'(1);
                wr_en       = 1'b1;
            end
            OP_DIFF: begin
                repeat_next = '0;
                match_next  = work_byte;
                fill_next   = fill_reg + FW'(1);
                wr_en       = 1'b1;
            end
            OP_CLOSE: begin
                // run body is never read back from the store
                repeat_next = RW'(RUN_THRESH);
                fill_next   = FW'(RUN_THRESH + 2);
            end
            OP_CLEAR: begin
                repeat_next = '0;
                match_next  = '0;
                fill_next   = FW'(1);
            end
            default: begin
            end
        endcase

        rd_en   = cmd.adv && (cmd.hdr || !stat.body_last);
        rd_addr = cmd.hdr ? '0 : idx_reg[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= FW'(1);
            repeat_reg <= '0;
            match_reg  <= '0;
        end else begin
            fill_reg   <= fill_next;
            repeat_reg <= repeat_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_byte_reg <= s_item.in_byte;
            cur_last_reg <= s_item.last_in_block;
        end
        if (cmd.adv) begin
            if (cmd.hdr) begin
                idx_reg <= FW'(1);
            end else if (!stat.body_last) begin
                idx_reg <= idx_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= work_byte;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

### hdl/trle_pack.sv
`timescale 1ns / 1ps

module trle_pack #(
    parameter int OUT_WORD_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  trle_pkg::trle_emit_t emit,
    input  logic [7:0]           byte_data,
    output logic                 byte_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trle_pkg::trle_out_t  m_item
);
    import trle_pkg::*;

    localparam int CW = $clog2(OUT_WORD_BYTES + 1);
    localparam int WW = OUT_WORD_BYTES * 8;

    logic [WW-1:0] asm_word_reg;
    logic [CW-1:0] asm_cnt_reg;
    logic          m_valid_reg;
    trle_out_t     m_item_reg;

    logic [WW-1:0] word_next;
    logic [CW-1:0] cnt_inc;
    logic          word_end;
    logic          take;
    logic          push;

    always_comb begin
        for (int l = 0; l < OUT_WORD_BYTES; l++) begin
            if (CW'(l) == asm_cnt_reg) begin
                word_next[l*8 +: 8] = byte_data;
            end else if (CW'(l) < asm_cnt_reg) begin
                word_next[l*8 +: 8] = asm_word_reg[l*8 +: 8];
            end else begin
                word_next[l*8 +: 8] = 8'h00;
            end
        end
        cnt_inc    = asm_cnt_reg + CW'(1);
        word_end   = (asm_cnt_reg == CW'(OUT_WORD_BYTES - 1)) || emit.item_end;
        // hold the byte while a finished word cannot move to the output stage
        byte_ready = !word_end || !m_valid_reg || m_ready;
        take       = emit.valid && byte_ready;
        push       = take && word_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                asm_cnt_reg <= push ? '0 : cnt_inc;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            asm_word_reg <= word_next;
        end
        if (push) begin
            m_item_reg.out_bytes    <= 64'(word_next);
            m_item_reg.byte_count   <= 4'(cnt_inc);
            m_item_reg.last_of_item <= emit.item_end;
            m_item_reg.block_done   <= emit.block_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### hdl/targa_rle_packet_encoder.sv
`timescale 1ns / 1ps
// Targa RLE packet encoder.
// s_ channel: one uncompressed byte per transaction, last_in_block marks the
// final byte of a block. m_ channel: up to OUT_WORD_BYTES compressed bytes per
// transaction, first byte in bits 7:0, byte_count valid bytes, unused bytes zero;
// last_of_item flags the final word caused by an input byte, block_done the
// final word of a block.
// Timing: a byte that emits nothing leaves the encoder in S_IDLE, ready for the
// next byte. A byte that emits is followed by the header and body bytes of its
// packets on the single byte-wide emit path, which reads the packet store one
// entry per cycle while the packer does not stall. s_ready stays low until the
// last compressed byte of the transaction is packed. A word shows on m_ in the
// cycle after its last byte is packed.
// Reset (synchronous, aresetn low): no packet open, output register empty.
// The packet store needs no clearing pass; it is always written before read.
// Stall: a waiting m_ word holds in the output register; packing pauses only
// when a further word is complete and the register is still occupied.
module targa_rle_packet_encoder #(
    parameter int MAX_PACKET     = 128,
    parameter int OUT_WORD_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trle_pkg::trle_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output trle_pkg::trle_out_t m_item
);
    import trle_pkg::*;

`include "targa_rle_packet_encoder_macros.svh"

    trle_cmd_t  cmd;
    trle_stat_t stat;
    trle_emit_t emit;
    logic [7:0] byte_data;
    logic       byte_ready;

    // Sequencer: decide the packet action per byte and walk header/body bytes.
    trle_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .stat       (stat),
        .byte_ready (byte_ready),
        .cmd        (cmd),
        .emit       (emit)
    );

    // Packet state, packet store and compressed-byte mux.
    trle_dpath #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .byte_data (byte_data)
    );

    // Gather bytes into words and hold them in the output register.
    trle_pack #(
        .OUT_WORD_BYTES (OUT_WORD_BYTES)
    ) u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit       (emit),
        .byte_data  (byte_data),
        .byte_ready (byte_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    // Never take a new byte while the previous one is still being emitted.
    `TRLE_ASSERT_NOW(a_no_accept_while_emit, emit.valid, !s_ready, "input accepted during emission")

    // The closing byte of a transaction must land as a flagged output word.
    `TRLE_ASSERT_NEXT(a_item_end_lands, emit.valid && emit.item_end && byte_ready, m_valid && m_item.last_of_item, "item end word missing")

    // A block end word is always the last word of its input byte.
    `TRLE_ASSERT_NOW(a_done_is_item_end, m_valid && m_item.block_done, m_item.last_of_item, "block_done without last_of_item")

    // Word fill stays within the configured word size.
    `TRLE_ASSERT_NOW(a_count_range, m_valid, (m_item.byte_count != 4'd0) && (m_item.byte_count <= 4'(OUT_WORD_BYTES)), "byte_count out of range")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import trle_pkg::*;

    localparam int MAX_PKT      = 128;
    localparam int WORD_BYTES   = 8;
    localparam int PHASE_ITEMS  = 20;   // random bytes per phase, at least
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int QUIET_LIMIT  = 5000; // cycles with no transaction at all
    localparam int TAIL_CYCLES  = 2 * (MAX_PKT + 4);

    // Shapes of a generated block and of the segments inside a mixed block.
    typedef enum int {
        SHAPE_MIXED,
        SHAPE_LONG_RUN,
        SHAPE_LONG_LITERAL
    } block_shape_t;

    typedef enum int {
        SEG_RUN,
        SEG_RANDOM,
        SEG_NARROW,
        SEG_PAIR
    } segment_kind_t;

    // Encoder model plus the queue of words still owed by the block.
    class rle_word_tracker;
        logic [7:0] pkt_buf [MAX_PKT];
        int         pkt_fill;
        int         run_reps;
        logic [7:0] cmp_byte;
        logic [7:0] emitted [$];
        trle_out_t  words_due [$];
        int         mismatches;

        function new();
            pkt_fill   = 1;
            run_reps   = 0;
            cmp_byte   = '0;
            mismatches = 0;
        endfunction

        function void dump_stored(int n);
            for (int i = 0; i < n; i++) emitted.push_back(pkt_buf[i]);
        endfunction

        function void start_packet(logic [7:0] b);
            run_reps   = 0;
            pkt_buf[0] = b;
            cmp_byte   = b;
            pkt_fill   = 2;
        endfunction

        function void append(logic [7:0] b);
            if (pkt_fill - 1 < MAX_PKT) pkt_buf[pkt_fill - 1] = b;
            pkt_fill++;
        endfunction

        // Encode one accepted byte and queue the words it produces.
        function void take_byte(trle_in_t it);
            logic [7:0] b;
            int         nwords;
            int         cnt;
            trle_out_t  w;
            b = it.in_byte;
            emitted.delete();

            // Full packet waiting: send it before looking at the new byte.
            if (pkt_fill >= MAX_PKT + 1) begin
                if (run_reps >= RUN_THRESH) begin
                    emitted.push_back(RUN_FLAG | 8'(MAX_PKT - 1));
                    emitted.push_back(cmp_byte);
                end else begin
                    emitted.push_back(8'(MAX_PKT - 1));
                    dump_stored(MAX_PKT);
                end
                pkt_fill = 1;
            end

            if (pkt_fill <= 1) begin
                start_packet(b);
            end else if (b == cmp_byte) begin
                run_reps = (run_reps + 1) & 255;
                // Third equal byte: close the literal ahead of the new run.
                if (run_reps == RUN_THRESH && pkt_fill > RUN_THRESH + 1) begin
                    emitted.push_back(8'(pkt_fill - 4));
                    dump_stored(pkt_fill - 3);
                    pkt_buf[0] = b;
                    pkt_buf[1] = b;
                    pkt_fill   = RUN_THRESH + 1;
                end
                append(b);
            end else if (run_reps >= RUN_THRESH) begin
                emitted.push_back(RUN_FLAG | 8'(run_reps));
                emitted.push_back(cmp_byte);
                start_packet(b);
            end else begin
                run_reps = 0;
                cmp_byte = b;
                append(b);
            end

            if (it.last_in_block) begin
                cnt = pkt_fill - 1;
                if (cnt >= 1) begin
                    if (run_reps >= RUN_THRESH) begin
                        emitted.push_back(RUN_FLAG | 8'(cnt - 1));
                        emitted.push_back(cmp_byte);
                    end else begin
                        emitted.push_back(8'(cnt - 1));
                        dump_stored(cnt);
                    end
                end
                pkt_fill = 1;
                run_reps = 0;
                cmp_byte = '0;
            end

            nwords = (emitted.size() + WORD_BYTES - 1) / WORD_BYTES;
            for (int k = 0; k < nwords; k++) begin
                w = '0;
                for (int i = 0; i < WORD_BYTES && k * WORD_BYTES + i < emitted.size(); i++) begin
                    w.out_bytes[8 * i +: 8] = emitted[k * WORD_BYTES + i];
                    w.byte_count            = w.byte_count + 4'd1;
                end
                w.last_of_item = (k == nwords - 1);
                w.block_done   = it.last_in_block && (k == nwords - 1);
                words_due.push_back(w);
            end
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one output transaction with the oldest owed word.
        function void check_word(trle_out_t got);
            trle_out_t want;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h count %0d",
                         $time, got.out_bytes, got.byte_count);
                mismatches++;
                return;
            end
            want = words_due.pop_front();
            cmp_field("out_bytes", want.out_bytes, got.out_bytes);
            cmp_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
            cmp_field("last_of_item", 64'(want.last_of_item), 64'(got.last_of_item));
            cmp_field("block_done", 64'(want.block_done), 64'(got.block_done));
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    trle_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    trle_out_t m_item;

    int   src_idle_pct  = 0;
    int   sink_stall_pct = 0;
    logic hold_off      = 1'b0;
    int   items_sent    = 0;
    int   quiet_cycles  = 0;

    logic [7:0]      blk_q [$];
    rle_word_tracker tracker;

    targa_rle_packet_encoder #(
        .MAX_PACKET     (MAX_PKT),
        .OUT_WORD_BYTES (WORD_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    // Receiver: stall at random, and hold ready low for the whole hold-off.
    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every output transaction against the owed words.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_word(m_item);
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte; idle first at random, then hold valid until accepted.
    // Valid is left high on return so a back-to-back byte never toggles it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        trle_in_t it;
        it.in_byte       = b;
        it.last_in_block = last;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_byte(it);
        items_sent++;
    endtask

    // Send blk_q as one block, last_in_block on the final byte.
    task automatic send_block();
        for (int i = 0; i < blk_q.size(); i++) send_byte(blk_q[i], i == blk_q.size() - 1);
    endtask

    // Build a block of the given shape into blk_q and send it.
    task automatic random_block(input block_shape_t shape);
        logic [7:0]    v;
        int            nseg;
        segment_kind_t kind;
        blk_q.delete();
        v = 8'($urandom);
        case (shape)
            SHAPE_LONG_RUN: begin
                // Straddle the full-packet boundary, sometimes with a tail.
                repeat ($urandom_range(MAX_PKT - 2, MAX_PKT + 3)) blk_q.push_back(v);
                repeat ($urandom_range(0, 2)) blk_q.push_back(8'($urandom));
            end
            SHAPE_LONG_LITERAL: begin
                // Each byte differs from the one before it.
                repeat ($urandom_range(MAX_PKT - 1, MAX_PKT + 5)) begin
                    v = v + 8'($urandom_range(1, 255));
                    blk_q.push_back(v);
                end
            end
            default: begin
                nseg = $urandom_range(1, 6);
                repeat (nseg) begin
                    kind = segment_kind_t'($urandom_range(SEG_RUN, SEG_PAIR));
                    v    = 8'($urandom);
                    case (kind)
                        SEG_RUN: begin
                            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(7, 20)
                                                              : $urandom_range(1, 6))
                                blk_q.push_back(v);
                        end
                        SEG_RANDOM: begin
                            repeat ($urandom_range(1, 8)) blk_q.push_back(8'($urandom));
                        end
                        SEG_NARROW: begin
                            // Two-value alphabet: frequent accidental pairs and triples.
                            repeat ($urandom_range(2, 8))
                                blk_q.push_back(v + 8'($urandom_range(0, 1)));
                        end
                        default: begin
                            blk_q.push_back(v);
                            blk_q.push_back(v);
                        end
                    endcase
                end
            end
        endcase
        send_block();
    endtask

    // Mostly short mixed blocks, with an occasional long one.
    task automatic random_phase(input int budget);
        int target;
        int pick;
        target = items_sent + budget;
        while (items_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      random_block(SHAPE_LONG_RUN);
            else if (pick == 1) random_block(SHAPE_LONG_LITERAL);
            else                random_block(SHAPE_MIXED);
        end
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, two equal bytes staying literal, a bare run,
        // a literal closed by a run, and runs broken by a different byte.
        blk_q = {8'h00};
        send_block();
        blk_q = {8'hFF};
        send_block();
        blk_q = {8'h41, 8'h41};
        send_block();
        blk_q = {8'h80, 8'h80, 8'h80};
        send_block();
        blk_q = {8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04};
        send_block();
        blk_q = {8'h55, 8'h55, 8'h55, 8'h55, 8'h7F, 8'hAA};
        send_block();
        blk_q = {8'h10, 8'h20, 8'h20, 8'h30};
        send_block();

        // No idling, with a long run block up front.
        random_block(SHAPE_LONG_RUN);
        random_phase(PHASE_ITEMS);

        src_idle_pct = 52;
        random_phase(PHASE_ITEMS);

        src_idle_pct   = 0;
        sink_stall_pct = 52;
        random_phase(PHASE_ITEMS);

        src_idle_pct   = 20;
        sink_stall_pct = 20;
        random_phase(PHASE_ITEMS);

        // Hold the receiver off while bytes keep coming, so the block backs up.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        random_block(SHAPE_LONG_LITERAL);
        random_phase(PHASE_ITEMS);

        // Drain: wait for every owed word, then watch for strays.
        s_valid <= 1'b0;
        while (tracker.words_due.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.words_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/trle_pkg.sv
hdl/trle_ctrl.sv
hdl/trle_dpath.sv
hdl/trle_pack.sv
hdl/targa_rle_packet_encoder.sv
test/tb_top.sv
